>>> rtl/mcnms_pkg.sv
package mcnms_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int CLASS_W = 7;
    localparam int DECAY_W = 17;
    localparam int KEPT_W  = 7;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam int PIX_ONE = 16;
    localparam logic [DECAY_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [SCORE_W-1:0] HALF_Q16 = 16'd32768;

    localparam logic [15:0]        OVERLAP_RESET = 16'd32768;
    localparam logic [DECAY_W-1:0] DECAY_RESET   = 17'd65536;
    localparam logic [KEPT_W-1:0]  MAX_KEPT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEPT = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SCAN_START,
        OP_SCAN,
        OP_SCAN_TAIL,
        OP_PICK,
        OP_CAND,
        OP_KRD,
        OP_KIDX,
        OP_KDAT,
        OP_GEO,
        OP_M_INTER,
        OP_M_A1,
        OP_M_A2,
        OP_UNI,
        OP_M_LO,
        OP_M_HI,
        OP_CMP,
        OP_KEEP,
        OP_M_DECAY,
        OP_WR_THR,
        OP_EMIT_START,
        OP_EMIT_RD,
        OP_EMIT_IDX,
        OP_EMIT_LOAD,
        OP_EMPTY
    } dp_op_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_PICK,
        S_CAND,
        S_KCHK,
        S_KRD,
        S_KIDX,
        S_KDAT,
        S_GEO,
        S_INTER,
        S_A1,
        S_A2,
        S_UNI,
        S_LO,
        S_HI,
        S_CMP,
        S_KEEP,
        S_DECAY,
        S_WRTHR,
        S_EMIT_RD,
        S_EMIT_IDX,
        S_EMIT_LOAD,
        S_EMPTY
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_close;
        logic init_last;
        logic kept_full;
        logic box_empty;
        logic kc_zero;
        logic scan_last;
        logic found;
        logic j_end;
        logic class_match;
        logic survive;
        logic decay_ok;
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

>>> rtl/multiclass_box_nms.sv
// Multi-class greedy box suppression, one frame at a time.
// Input channel (in_valid / in_stall): one box word per cycle while loading.
// The word carrying frame_end closes the frame; in_stall then stays high
// until the frame's last result has been placed in the output register.
// Boxes with class_id out of range are ignored; boxes beyond MAX_BOXES
// are dropped and store_overflow is raised on that frame's results.
//
// After frame close the per-class thresholds are preset, then each walk step
// scans the N stored boxes for the best score, fetches the candidate, checks
// it against the kept boxes and, for each kept box of the same class, works
// out the overlap (one shared 20x20 multiplier does intersection, both areas,
// the two halves of thr*union and the threshold decay), then closes the check
// and records a keep.
//
// Output channel (out_valid / out_stall): up to max_kept words, run_end on
// the last; a frame with no survivor gives a single no_detection word. The
// output register holds its word under stall; loading of the next frame
// starts once the last word is registered. Configuration writes go to
// cfg_index 0..2; the user writes only when idle, not enforced by the block.
// Reset clears counters and presets the registers; no clearing pass.
module multiclass_box_nms #(
    parameter int MAX_BOXES   = 1024,
    parameter int MAX_KEEP    = 64,
    parameter int NUM_CLASSES = 80
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_left,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_top,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_right,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_bottom,
    input  logic [mcnms_pkg::SCORE_W-1:0]      box_score,
    input  logic [mcnms_pkg::CLASS_W-1:0]      class_id,
    input  logic                               frame_end,
    input  logic                               cfg_write,
    input  logic [mcnms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcnms_pkg::CFG_W-1:0]        cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mcnms_pkg::CLASS_W-1:0]      out_label,
    output logic [mcnms_pkg::SCORE_W-1:0]      out_score,
    output logic [mcnms_pkg::COORD_W-1:0]      out_left,
    output logic [mcnms_pkg::COORD_W-1:0]      out_top,
    output logic [mcnms_pkg::COORD_W-1:0]      out_right,
    output logic [mcnms_pkg::COORD_W-1:0]      out_bottom,
    output logic                               run_end,
    output logic                               no_detection,
    output logic                               store_overflow
);
    mcnms_pkg::dp_cmd_t    cmd;
    mcnms_pkg::dp_status_t stat;

    // sequencer: load, threshold preset, walk, emit
    mcnms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // stores, search, overlap arithmetic and output register
    mcnms_dp #(
        .MAX_BOXES   (MAX_BOXES),
        .MAX_KEEP    (MAX_KEEP),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .box_left       (box_left),
        .box_top        (box_top),
        .box_right      (box_right),
        .box_bottom     (box_bottom),
        .box_score      (box_score),
        .class_id       (class_id),
        .frame_end      (frame_end),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_label      (out_label),
        .out_score      (out_score),
        .out_left       (out_left),
        .out_top        (out_top),
        .out_right      (out_right),
        .out_bottom     (out_bottom),
        .run_end        (run_end),
        .no_detection   (no_detection),
        .store_overflow (store_overflow)
    );
endmodule

>>> rtl/mcnms_ram.sv
module mcnms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ABITS-1:0]     waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ABITS-1:0]     raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/mcnms_ctrl.sv
module mcnms_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcnms_pkg::dp_status_t  stat,
    output mcnms_pkg::dp_cmd_t     cmd
);
    mcnms_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcnms_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcnms_pkg::S_LOAD:      if (stat.frame_close) state_next = mcnms_pkg::S_INIT;
            mcnms_pkg::S_INIT:      if (stat.init_last) state_next = mcnms_pkg::S_CHECK;
            mcnms_pkg::S_CHECK:
            begin
                if (stat.kept_full || stat.box_empty)
                    state_next = stat.kc_zero ? mcnms_pkg::S_EMPTY : mcnms_pkg::S_EMIT_RD;
                else
                    state_next = mcnms_pkg::S_SCAN;
            end
            mcnms_pkg::S_SCAN:      if (stat.scan_last) state_next = mcnms_pkg::S_SCAN_END;
            mcnms_pkg::S_SCAN_END:  state_next = mcnms_pkg::S_PICK;
            mcnms_pkg::S_PICK:
            begin
                if (stat.found)
                    state_next = mcnms_pkg::S_CAND;
                else
                    state_next = stat.kc_zero ? mcnms_pkg::S_EMPTY : mcnms_pkg::S_EMIT_RD;
            end
            mcnms_pkg::S_CAND:      state_next = mcnms_pkg::S_KCHK;
            mcnms_pkg::S_KCHK:
                state_next = stat.j_end ? mcnms_pkg::S_KEEP : mcnms_pkg::S_KRD;
            mcnms_pkg::S_KRD:       state_next = mcnms_pkg::S_KIDX;
            mcnms_pkg::S_KIDX:      state_next = mcnms_pkg::S_KDAT;
            mcnms_pkg::S_KDAT:
                state_next = stat.class_match ? mcnms_pkg::S_GEO : mcnms_pkg::S_KCHK;
            mcnms_pkg::S_GEO:       state_next = mcnms_pkg::S_INTER;
            mcnms_pkg::S_INTER:     state_next = mcnms_pkg::S_A1;
            mcnms_pkg::S_A1:        state_next = mcnms_pkg::S_A2;
            mcnms_pkg::S_A2:        state_next = mcnms_pkg::S_UNI;
            mcnms_pkg::S_UNI:       state_next = mcnms_pkg::S_LO;
            mcnms_pkg::S_LO:        state_next = mcnms_pkg::S_HI;
            mcnms_pkg::S_HI:        state_next = mcnms_pkg::S_CMP;
            mcnms_pkg::S_CMP:
                state_next = stat.survive ? mcnms_pkg::S_KCHK : mcnms_pkg::S_CHECK;
            mcnms_pkg::S_KEEP:
                state_next = stat.decay_ok ? mcnms_pkg::S_DECAY : mcnms_pkg::S_CHECK;
            mcnms_pkg::S_DECAY:     state_next = mcnms_pkg::S_WRTHR;
            mcnms_pkg::S_WRTHR:     state_next = mcnms_pkg::S_CHECK;
            mcnms_pkg::S_EMIT_RD:   if (stat.out_free) state_next = mcnms_pkg::S_EMIT_IDX;
            mcnms_pkg::S_EMIT_IDX:  state_next = mcnms_pkg::S_EMIT_LOAD;
            mcnms_pkg::S_EMIT_LOAD:
                state_next = stat.emit_last ? mcnms_pkg::S_LOAD : mcnms_pkg::S_EMIT_RD;
            mcnms_pkg::S_EMPTY:     if (stat.out_free) state_next = mcnms_pkg::S_LOAD;
            default:                state_next = mcnms_pkg::S_LOAD;
        endcase
    end

    // datapath command
    always_comb
    begin
        cmd.op = mcnms_pkg::OP_NONE;
        unique case (state_reg)
            mcnms_pkg::S_LOAD:      cmd.op = mcnms_pkg::OP_LOAD;
            mcnms_pkg::S_INIT:      cmd.op = mcnms_pkg::OP_INIT;
            mcnms_pkg::S_CHECK:
                cmd.op = (stat.kept_full || stat.box_empty) ? mcnms_pkg::OP_EMIT_START
                                                            : mcnms_pkg::OP_SCAN_START;
            mcnms_pkg::S_SCAN:      cmd.op = mcnms_pkg::OP_SCAN;
            mcnms_pkg::S_SCAN_END:  cmd.op = mcnms_pkg::OP_SCAN_TAIL;
            mcnms_pkg::S_PICK:
                cmd.op = stat.found ? mcnms_pkg::OP_PICK : mcnms_pkg::OP_EMIT_START;
            mcnms_pkg::S_CAND:      cmd.op = mcnms_pkg::OP_CAND;
            mcnms_pkg::S_KCHK:      cmd.op = mcnms_pkg::OP_NONE;
            mcnms_pkg::S_KRD:       cmd.op = mcnms_pkg::OP_KRD;
            mcnms_pkg::S_KIDX:      cmd.op = mcnms_pkg::OP_KIDX;
            mcnms_pkg::S_KDAT:      cmd.op = mcnms_pkg::OP_KDAT;
            mcnms_pkg::S_GEO:       cmd.op = mcnms_pkg::OP_GEO;
            mcnms_pkg::S_INTER:     cmd.op = mcnms_pkg::OP_M_INTER;
            mcnms_pkg::S_A1:        cmd.op = mcnms_pkg::OP_M_A1;
            mcnms_pkg::S_A2:        cmd.op = mcnms_pkg::OP_M_A2;
            mcnms_pkg::S_UNI:       cmd.op = mcnms_pkg::OP_UNI;
            mcnms_pkg::S_LO:        cmd.op = mcnms_pkg::OP_M_LO;
            mcnms_pkg::S_HI:        cmd.op = mcnms_pkg::OP_M_HI;
            mcnms_pkg::S_CMP:       cmd.op = mcnms_pkg::OP_CMP;
            mcnms_pkg::S_KEEP:      cmd.op = mcnms_pkg::OP_KEEP;
            mcnms_pkg::S_DECAY:     cmd.op = mcnms_pkg::OP_M_DECAY;
            mcnms_pkg::S_WRTHR:     cmd.op = mcnms_pkg::OP_WR_THR;
            mcnms_pkg::S_EMIT_RD:
                cmd.op = stat.out_free ? mcnms_pkg::OP_EMIT_RD : mcnms_pkg::OP_NONE;
            mcnms_pkg::S_EMIT_IDX:  cmd.op = mcnms_pkg::OP_EMIT_IDX;
            mcnms_pkg::S_EMIT_LOAD: cmd.op = mcnms_pkg::OP_EMIT_LOAD;
            mcnms_pkg::S_EMPTY:
                cmd.op = stat.out_free ? mcnms_pkg::OP_EMPTY : mcnms_pkg::OP_NONE;
            default:                cmd.op = mcnms_pkg::OP_NONE;
        endcase
    end
endmodule

>>> rtl/mcnms_dp.sv
module mcnms_dp #(
    parameter int MAX_BOXES   = 1024,
    parameter int MAX_KEEP    = 64,
    parameter int NUM_CLASSES = 80
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcnms_pkg::dp_cmd_t                 cmd,
    output mcnms_pkg::dp_status_t              stat,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_left,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_top,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_right,
    input  logic [mcnms_pkg::COORD_W-1:0]      box_bottom,
    input  logic [mcnms_pkg::SCORE_W-1:0]      box_score,
    input  logic [mcnms_pkg::CLASS_W-1:0]      class_id,
    input  logic                               frame_end,
    input  logic                               cfg_write,
    input  logic [mcnms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcnms_pkg::CFG_W-1:0]        cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mcnms_pkg::CLASS_W-1:0]      out_label,
    output logic [mcnms_pkg::SCORE_W-1:0]      out_score,
    output logic [mcnms_pkg::COORD_W-1:0]      out_left,
    output logic [mcnms_pkg::COORD_W-1:0]      out_top,
    output logic [mcnms_pkg::COORD_W-1:0]      out_right,
    output logic [mcnms_pkg::COORD_W-1:0]      out_bottom,
    output logic                               run_end,
    output logic                               no_detection,
    output logic                               store_overflow
);
    localparam int AW   = $clog2(MAX_BOXES);
    localparam int CNTW = AW + 1;
    localparam int KAW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int KCW  = $clog2(MAX_KEEP + 1);
    localparam int CAW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SCW  = mcnms_pkg::SCORE_W + mcnms_pkg::CLASS_W;
    localparam int CDW  = 4 * mcnms_pkg::COORD_W;

    mcnms_pkg::dp_op_t op;
    assign op = cmd.op;

    // configuration
    logic [15:0] ovl_reg;
    logic [mcnms_pkg::DECAY_W-1:0] eta_reg;
    logic [mcnms_pkg::KEPT_W-1:0] maxk_reg;

    // control counters
    logic [CNTW-1:0] box_cnt_reg;
    logic            ovf_reg;
    logic [CAW-1:0]  ci_reg;
    logic [AW-1:0]   scan_i_reg;
    logic            rd_issued_reg;
    logic            found_reg;
    logic [KCW-1:0]  j_reg;
    logic [KCW-1:0]  kc_reg;
    logic [KCW-1:0]  e_reg;
    logic            out_valid_reg;

    // payload
    logic [AW-1:0]   rd_idx_reg;
    logic [AW-1:0]   best_idx_reg;
    logic [15:0]     best_score_reg;
    logic [6:0]      best_cls_reg;
    logic [15:0]     c_l_reg, c_t_reg, c_r_reg, c_b_reg;
    logic [15:0]     k_l_reg, k_t_reg, k_r_reg, k_b_reg;
    logic [15:0]     thr_reg;
    logic            disj_reg;
    logic signed [17:0] iw_reg, ih_reg;
    logic [16:0]     w1_reg, h1_reg, w2_reg, h2_reg;
    logic signed [39:0] prod_reg;
    logic signed [35:0] inter_reg;
    logic signed [39:0] a1_reg;
    logic signed [36:0] uni_reg;
    logic signed [39:0] lo_reg;

    // memory ports
    logic [CDW-1:0]  coord_q;
    logic [SCW-1:0]  score_q;
    logic            done_q;
    logic [AW-1:0]   kept_q;
    logic [15:0]     thr_q;
    logic [AW-1:0]   coord_ra, score_ra;
    logic            done_we;
    logic [AW-1:0]   done_wa;
    logic            thr_we;
    logic [CAW-1:0]  thr_wa;
    logic [15:0]     thr_wd;
    logic [KAW-1:0]  kept_ra;

    logic accept, cls_ok, room, ld_we;
    logic clear_frame, load_out, emit_last;
    logic sc_take;
    logic [15:0] sc_s;
    logic [6:0]  sc_c;

    assign in_stall = (op != mcnms_pkg::OP_LOAD);
    assign accept   = (op == mcnms_pkg::OP_LOAD) && in_valid;
    assign cls_ok   = 11'(class_id) < 11'(NUM_CLASSES);
    assign room     = box_cnt_reg < CNTW'(MAX_BOXES);
    assign ld_we    = accept && cls_ok && room;

    assign done_we = ld_we || (op == mcnms_pkg::OP_PICK);
    assign done_wa = ld_we ? box_cnt_reg[AW-1:0] : best_idx_reg;
    assign coord_ra = (op == mcnms_pkg::OP_PICK) ? best_idx_reg : kept_q;
    assign score_ra = (op == mcnms_pkg::OP_SCAN) ? scan_i_reg : kept_q;
    assign kept_ra  = (op == mcnms_pkg::OP_EMIT_RD) ? e_reg[KAW-1:0] : j_reg[KAW-1:0];
    assign thr_we   = (op == mcnms_pkg::OP_INIT) || (op == mcnms_pkg::OP_WR_THR);
    assign thr_wa   = (op == mcnms_pkg::OP_INIT) ? ci_reg : CAW'(best_cls_reg);
    assign thr_wd   = (op == mcnms_pkg::OP_INIT) ? ovl_reg : prod_reg[31:16];

    mcnms_ram #(.WIDTH(CDW), .DEPTH(MAX_BOXES)) u_coord (
        .clk   (clk),
        .we    (ld_we),
        .waddr (box_cnt_reg[AW-1:0]),
        .wdata ({box_bottom, box_right, box_top, box_left}),
        .raddr (coord_ra),
        .rdata (coord_q)
    );

    mcnms_ram #(.WIDTH(SCW), .DEPTH(MAX_BOXES)) u_score (
        .clk   (clk),
        .we    (ld_we),
        .waddr (box_cnt_reg[AW-1:0]),
        .wdata ({class_id, box_score}),
        .raddr (score_ra),
        .rdata (score_q)
    );

    mcnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_done (
        .clk   (clk),
        .we    (done_we),
        .waddr (done_wa),
        .wdata (op == mcnms_pkg::OP_PICK),
        .raddr (scan_i_reg),
        .rdata (done_q)
    );

    mcnms_ram #(.WIDTH(AW), .DEPTH(MAX_KEEP)) u_kept (
        .clk   (clk),
        .we    (op == mcnms_pkg::OP_KEEP),
        .waddr (kc_reg[KAW-1:0]),
        .wdata (best_idx_reg),
        .raddr (kept_ra),
        .rdata (kept_q)
    );

    mcnms_ram #(.WIDTH(16), .DEPTH(NUM_CLASSES)) u_thr (
        .clk   (clk),
        .we    (thr_we),
        .waddr (thr_wa),
        .wdata (thr_wd),
        .raddr (CAW'(best_cls_reg)),
        .rdata (thr_q)
    );

    // best-candidate search, one stored box per cycle
    assign sc_s = score_q[15:0];
    assign sc_c = score_q[22:16];
    assign sc_take = rd_issued_reg && !done_q &&
                     ((op == mcnms_pkg::OP_SCAN) || (op == mcnms_pkg::OP_SCAN_TAIL)) &&
                     (!found_reg || (sc_s > best_score_reg) ||
                      ((sc_s == best_score_reg) && (sc_c < best_cls_reg)));

    assign emit_last   = ((KCW+1)'(e_reg) + (KCW+1)'(1)) == (KCW+1)'(kc_reg);
    assign load_out    = (op == mcnms_pkg::OP_EMIT_LOAD) || (op == mcnms_pkg::OP_EMPTY);
    assign clear_frame = (op == mcnms_pkg::OP_EMPTY) ||
                         ((op == mcnms_pkg::OP_EMIT_LOAD) && emit_last);

    // geometry of candidate against one kept box
    logic        geo_disj, inv1, inv2;
    logic [15:0] minr, maxl, minb, maxt;
    logic signed [17:0] iw_n, ih_n;
    logic [16:0] w1_n, h1_n, w2_n, h2_n;

    always_comb
    begin
        geo_disj = (k_l_reg > c_r_reg) || (k_r_reg < c_l_reg) ||
                   (k_t_reg > c_b_reg) || (k_b_reg < c_t_reg);
        minr = (c_r_reg < k_r_reg) ? c_r_reg : k_r_reg;
        maxl = (c_l_reg > k_l_reg) ? c_l_reg : k_l_reg;
        minb = (c_b_reg < k_b_reg) ? c_b_reg : k_b_reg;
        maxt = (c_t_reg > k_t_reg) ? c_t_reg : k_t_reg;
        iw_n = $signed({2'b00, minr}) - $signed({2'b00, maxl}) + 18'sd16;
        ih_n = $signed({2'b00, minb}) - $signed({2'b00, maxt}) + 18'sd16;
        inv1 = (c_r_reg < c_l_reg) || (c_b_reg < c_t_reg);
        inv2 = (k_r_reg < k_l_reg) || (k_b_reg < k_t_reg);
        w1_n = inv1 ? 17'd0 : ({1'b0, c_r_reg} - {1'b0, c_l_reg} + 17'd16);
        h1_n = inv1 ? 17'd0 : ({1'b0, c_b_reg} - {1'b0, c_t_reg} + 17'd16);
        w2_n = inv2 ? 17'd0 : ({1'b0, k_r_reg} - {1'b0, k_l_reg} + 17'd16);
        h2_n = inv2 ? 17'd0 : ({1'b0, k_b_reg} - {1'b0, k_t_reg} + 17'd16);
    end

    // shared multiplier
    logic signed [19:0] mul_a, mul_b;
    logic signed [39:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            mcnms_pkg::OP_M_INTER:
            begin
                mul_a = 20'(iw_reg);
                mul_b = 20'(ih_reg);
            end
            mcnms_pkg::OP_M_A1:
            begin
                mul_a = $signed({3'b000, w1_reg});
                mul_b = $signed({3'b000, h1_reg});
            end
            mcnms_pkg::OP_M_A2:
            begin
                mul_a = $signed({3'b000, w2_reg});
                mul_b = $signed({3'b000, h2_reg});
            end
            mcnms_pkg::OP_M_LO:
            begin
                mul_a = $signed({4'b0000, thr_reg});
                mul_b = $signed({2'b00, uni_reg[17:0]});
            end
            mcnms_pkg::OP_M_HI:
            begin
                mul_a = $signed({4'b0000, thr_reg});
                mul_b = 20'($signed(uni_reg[36:18]));
            end
            mcnms_pkg::OP_M_DECAY:
            begin
                mul_a = $signed({4'b0000, thr_reg});
                mul_b = $signed({3'b000, eta_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // inter*65536 <= thr*union, with thr*union rebuilt from two partial products
    logic signed [55:0] cmp_lhs, cmp_rhs;
    assign cmp_lhs = 56'(inter_reg) <<< 16;
    assign cmp_rhs = (56'(prod_reg) <<< 18) + 56'(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovl_reg       <= mcnms_pkg::OVERLAP_RESET;
            eta_reg       <= mcnms_pkg::DECAY_RESET;
            maxk_reg      <= mcnms_pkg::MAX_KEPT_RESET;
            box_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            ci_reg        <= '0;
            scan_i_reg    <= '0;
            rd_issued_reg <= 1'b0;
            found_reg     <= 1'b0;
            j_reg         <= '0;
            kc_reg        <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mcnms_pkg::CFG_OVERLAP:  ovl_reg  <= cfg_data[15:0];
                    mcnms_pkg::CFG_DECAY:    eta_reg  <= cfg_data;
                    mcnms_pkg::CFG_MAX_KEPT: maxk_reg <= cfg_data[6:0];
                    default:                 ;
                endcase
            end
            if (accept && cls_ok)
            begin
                if (room)
                    box_cnt_reg <= box_cnt_reg + CNTW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (clear_frame)
            begin
                box_cnt_reg <= '0;
                kc_reg      <= '0;
                ovf_reg     <= 1'b0;
            end
            case (op)
                mcnms_pkg::OP_LOAD:       ci_reg <= '0;
                mcnms_pkg::OP_INIT:       ci_reg <= ci_reg + CAW'(1);
                mcnms_pkg::OP_SCAN_START:
                begin
                    scan_i_reg    <= '0;
                    rd_issued_reg <= 1'b0;
                    found_reg     <= 1'b0;
                end
                mcnms_pkg::OP_SCAN:
                begin
                    scan_i_reg    <= scan_i_reg + AW'(1);
                    rd_issued_reg <= 1'b1;
                end
                mcnms_pkg::OP_SCAN_TAIL:  rd_issued_reg <= 1'b0;
                mcnms_pkg::OP_PICK:       j_reg <= '0;
                mcnms_pkg::OP_KDAT:       j_reg <= j_reg + KCW'(1);
                mcnms_pkg::OP_KEEP:       kc_reg <= kc_reg + KCW'(1);
                mcnms_pkg::OP_EMIT_START: e_reg <= '0;
                mcnms_pkg::OP_EMIT_LOAD:  e_reg <= e_reg + KCW'(1);
                default:                  ;
            endcase
            if (sc_take)
                found_reg <= 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (op == mcnms_pkg::OP_SCAN)
            rd_idx_reg <= scan_i_reg;
        if (sc_take)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_score_reg <= sc_s;
            best_cls_reg   <= sc_c;
        end
        case (op)
            mcnms_pkg::OP_CAND:
            begin
                {c_b_reg, c_r_reg, c_t_reg, c_l_reg} <= coord_q;
                thr_reg <= thr_q;
            end
            mcnms_pkg::OP_KDAT:
                {k_b_reg, k_r_reg, k_t_reg, k_l_reg} <= coord_q;
            mcnms_pkg::OP_GEO:
            begin
                disj_reg <= geo_disj;
                iw_reg   <= iw_n;
                ih_reg   <= ih_n;
                w1_reg   <= w1_n;
                h1_reg   <= h1_n;
                w2_reg   <= w2_n;
                h2_reg   <= h2_n;
            end
            mcnms_pkg::OP_M_A1:  inter_reg <= prod_reg[35:0];
            mcnms_pkg::OP_M_A2:  a1_reg <= prod_reg;
            mcnms_pkg::OP_UNI:   uni_reg <= 37'(a1_reg + prod_reg - 40'(inter_reg));
            mcnms_pkg::OP_M_HI:  lo_reg <= prod_reg;
            mcnms_pkg::OP_EMIT_LOAD:
            begin
                out_label      <= score_q[22:16] + 7'd1;
                out_score      <= score_q[15:0];
                {out_bottom, out_right, out_top, out_left} <= coord_q;
                run_end        <= emit_last;
                no_detection   <= 1'b0;
                store_overflow <= ovf_reg;
            end
            mcnms_pkg::OP_EMPTY:
            begin
                out_label      <= '0;
                out_score      <= '0;
                out_left       <= '0;
                out_top        <= '0;
                out_right      <= '0;
                out_bottom     <= '0;
                run_end        <= 1'b1;
                no_detection   <= 1'b1;
                store_overflow <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

    logic [7:0] lim;
    assign lim = (8'(maxk_reg) > 8'(MAX_KEEP)) ? 8'(MAX_KEEP) : 8'(maxk_reg);

    always_comb
    begin
        stat.frame_close = in_valid && frame_end;
        stat.init_last   = (ci_reg == CAW'(NUM_CLASSES - 1));
        stat.kept_full   = 8'(kc_reg) >= lim;
        stat.box_empty   = (box_cnt_reg == '0);
        stat.kc_zero     = (kc_reg == '0);
        stat.scan_last   = ({1'b0, scan_i_reg} == (box_cnt_reg - CNTW'(1)));
        stat.found       = found_reg;
        stat.j_end       = (j_reg == kc_reg);
        stat.class_match = (score_q[22:16] == best_cls_reg);
        stat.survive     = disj_reg || (cmp_lhs <= cmp_rhs);
        stat.decay_ok    = (eta_reg < mcnms_pkg::ONE_Q16) && (thr_reg > mcnms_pkg::HALF_Q16);
        stat.out_free    = !out_valid_reg || !out_stall;
        stat.emit_last   = emit_last;
    end
endmodule

>>> rtl/mcnms_checker.sv
module mcnms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       frame_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] out_label,
    input logic [15:0] out_score,
    input logic       run_end,
    input logic       no_detection
);
    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_score) && $stable(out_label))
        else $error("stalled result word changed");

    // stop loading once the frame is closed
    a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && frame_end |=> in_stall)
        else $error("input taken right after frame close");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_detection |-> run_end && (out_label == 7'd0) && (out_score == 16'd0))
        else $error("no_detection word malformed");

    a_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !no_detection |-> (out_label != 7'd0))
        else $error("kept box with zero label");
endmodule

bind multiclass_box_nms mcnms_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_label    (out_label),
    .out_score    (out_score),
    .run_end      (run_end),
    .no_detection (no_detection)
);

>>> bench/nms_checker.sv
module nms_checker
    import mcnms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [COORD_W-1:0]   box_left,
    input  logic [COORD_W-1:0]   box_top,
    input  logic [COORD_W-1:0]   box_right,
    input  logic [COORD_W-1:0]   box_bottom,
    input  logic [SCORE_W-1:0]   box_score,
    input  logic [CLASS_W-1:0]   class_id,
    input  logic                 frame_end,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [CLASS_W-1:0]   out_label,
    input  logic [SCORE_W-1:0]   out_score,
    input  logic [COORD_W-1:0]   out_left,
    input  logic [COORD_W-1:0]   out_top,
    input  logic [COORD_W-1:0]   out_right,
    input  logic [COORD_W-1:0]   out_bottom,
    input  logic                 run_end,
    input  logic                 no_detection,
    input  logic                 store_overflow,
    output int                   errors,
    output int                   pending,
    output int                   frames_closed,
    output int                   words_checked,
    output int                   overflow_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1024;
    localparam int KEEP_DEPTH  = 64;
    localparam int CLASS_COUNT = 80;

    typedef struct packed {
        logic [CLASS_W-1:0] label;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic               last;
        logic               empty;
        logic               ovf;
    } det_word_t;

    det_word_t kept_expect_q[$];

    logic [15:0] thr_init;
    logic [16:0] decay;
    logic [6:0]  keep_limit;

    logic [COORD_W-1:0] st_l[STORE_DEPTH];
    logic [COORD_W-1:0] st_t[STORE_DEPTH];
    logic [COORD_W-1:0] st_r[STORE_DEPTH];
    logic [COORD_W-1:0] st_b[STORE_DEPTH];
    logic [SCORE_W-1:0] st_s[STORE_DEPTH];
    logic [CLASS_W-1:0] st_c[STORE_DEPTH];
    int                 stored;
    bit                 dropped;

    function automatic longint area(longint l, longint t, longint r, longint b);
        if (r < l || b < t)
            return 0;
        return (r - l + PIX_ONE) * (b - t + PIX_ONE);
    endfunction

    // Candidate a stays alive next to kept box k at threshold thr.
    function automatic bit stays_alive(int a, int k, longint thr);
        longint l1, t1, r1, b1, l2, t2, r2, b2, iw, ih, inter, uni;
        l1 = st_l[a]; t1 = st_t[a]; r1 = st_r[a]; b1 = st_b[a];
        l2 = st_l[k]; t2 = st_t[k]; r2 = st_r[k]; b2 = st_b[k];
        if (l2 > r1 || r2 < l1 || t2 > b1 || b2 < t1)
            return 1'b1;
        iw = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2) + PIX_ONE;
        ih = ((b1 < b2) ? b1 : b2) - ((t1 > t2) ? t1 : t2) + PIX_ONE;
        inter = iw * ih;
        uni = area(l1, t1, r1, b1) + area(l2, t2, r2, b2) - inter;
        return (inter * 65536) <= (thr * uni);
    endfunction

    // Greedy walk over the closed frame; queue the words it gives out.
    task automatic predict_frame();
        bit        done[STORE_DEPTH];
        int        kept[KEEP_DEPTH];
        longint    thr[CLASS_COUNT];
        int        nkept, lim, best;
        bit        found, keep;
        int        bs, bc;
        det_word_t w;
        lim = (keep_limit > KEEP_DEPTH) ? KEEP_DEPTH : keep_limit;
        for (int c = 0; c < CLASS_COUNT; c++)
            thr[c] = thr_init;
        for (int i = 0; i < STORE_DEPTH; i++)
            done[i] = 1'b0;
        nkept = 0;
        while (nkept < lim)
        begin
            found = 1'b0;
            best = 0; bs = 0; bc = 0;
            for (int i = 0; i < stored; i++)
            begin
                if (!done[i] && (!found || st_s[i] > bs || (st_s[i] == bs && st_c[i] < bc)))
                begin
                    found = 1'b1; best = i; bs = st_s[i]; bc = st_c[i];
                end
            end
            if (!found)
                break;
            done[best] = 1'b1;
            keep = 1'b1;
            for (int j = 0; j < nkept; j++)
            begin
                if (st_c[kept[j]] == bc && !stays_alive(best, kept[j], thr[bc]))
                begin
                    keep = 1'b0;
                    break;
                end
            end
            if (keep)
            begin
                kept[nkept] = best;
                nkept++;
                if (decay < ONE_Q16 && thr[bc] > HALF_Q16)
                    thr[bc] = (thr[bc] * longint'(decay)) >>> 16;
            end
        end
        if (nkept == 0)
        begin
            w = '0;
            w.last = 1'b1;
            w.empty = 1'b1;
            w.ovf = dropped;
            kept_expect_q.insert(kept_expect_q.size(), w);
        end
        for (int k = 0; k < nkept; k++)
        begin
            w.label  = st_c[kept[k]] + 1'b1;
            w.score  = st_s[kept[k]];
            w.left   = st_l[kept[k]];
            w.top    = st_t[kept[k]];
            w.right  = st_r[kept[k]];
            w.bottom = st_b[kept[k]];
            w.last   = (k == nkept - 1);
            w.empty  = 1'b0;
            w.ovf    = dropped;
            kept_expect_q.insert(kept_expect_q.size(), w);
        end
    endtask

    task automatic check_field(string name, longint exp, longint act);
        if (exp != act)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp, act);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        det_word_t e;
        if (!rst_n)
        begin
            thr_init   <= OVERLAP_RESET;
            decay      <= DECAY_RESET;
            keep_limit <= MAX_KEPT_RESET;
            stored = 0;
            dropped = 1'b0;
            errors = 0;
            frames_closed = 0;
            words_checked = 0;
            overflow_frames = 0;
            kept_expect_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_OVERLAP)
                    thr_init <= cfg_data[15:0];
                else if (cfg_index == CFG_DECAY)
                    decay <= cfg_data[16:0];
                else if (cfg_index == CFG_MAX_KEPT)
                    keep_limit <= cfg_data[6:0];
            end
            if (in_valid && !in_stall)
            begin
                if (class_id < CLASS_COUNT)
                begin
                    if (stored < STORE_DEPTH)
                    begin
                        st_l[stored] = box_left;
                        st_t[stored] = box_top;
                        st_r[stored] = box_right;
                        st_b[stored] = box_bottom;
                        st_s[stored] = box_score;
                        st_c[stored] = class_id;
                        stored++;
                    end
                    else
                        dropped = 1'b1;
                end
                if (frame_end)
                begin
                    predict_frame();
                    frames_closed++;
                    if (dropped)
                        overflow_frames++;
                    stored = 0;
                    dropped = 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                words_checked++;
                if (kept_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, expected none, got label %0d",
                             $realtime, out_label);
                end
                else
                begin
                    e = kept_expect_q.pop_front();
                    check_field("out_label", e.label, out_label);
                    check_field("out_score", e.score, out_score);
                    check_field("out_left", e.left, out_left);
                    check_field("out_top", e.top, out_top);
                    check_field("out_right", e.right, out_right);
                    check_field("out_bottom", e.bottom, out_bottom);
                    check_field("run_end", e.last, run_end);
                    check_field("no_detection", e.empty, no_detection);
                    check_field("store_overflow", e.ovf, store_overflow);
                end
            end
        end
        pending = kept_expect_q.size();
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import mcnms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest quiet stretch: the receiver hold-off plus one short frame walk.
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [COORD_W-1:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
    logic [SCORE_W-1:0] box_score = '0;
    logic [CLASS_W-1:0] class_id = '0;
    logic frame_end = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OVERLAP;
    logic [CFG_W-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CLASS_W-1:0] out_label;
    logic [SCORE_W-1:0] out_score;
    logic [COORD_W-1:0] out_left, out_top, out_right, out_bottom;
    logic run_end, no_detection, store_overflow;

    int errors, pending, frames_closed, words_checked, overflow_frames;
    int boxes_sent = 0;
    bit calm = 1'b0;        // no idling on either side in the closing phase
    int hold_ticket = 0;    // bump to ask the receiver for one long hold-off

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    multiclass_box_nms u_dut (.*);

    nms_checker u_check (.*);

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(negedge clk)
    begin
        static int burst = 0;
        static int hold = 0;
        static int hold_seen = 0;
        if (hold_seen != hold_ticket)
        begin
            hold_seen = hold_ticket;
            hold = HOLD_CYCLES;
        end
        if (hold > 0)
        begin
            hold--;
            out_stall <= 1'b1;
        end
        else if (calm)
        begin
            burst = 0;
            out_stall <= 1'b0;
        end
        else if (burst > 0)
        begin
            burst--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            burst = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: count cycles with no word moving on either channel and no cfg_write.
    always @(posedge clk)
    begin
        static int quiet = 0;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words still expected", $realtime, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one box word, hold it until it is taken.
    task automatic send_box(int l, int t, int r, int b, int s, int c, bit last);
        int gap;
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        box_left = COORD_W'(l);
        box_top = COORD_W'(t);
        box_right = COORD_W'(r);
        box_bottom = COORD_W'(b);
        box_score = SCORE_W'(s);
        class_id = CLASS_W'(c);
        frame_end = last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        boxes_sent++;
    endtask

    // Drop valid, drain every expected word, then let the walk machinery settle.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_regs(int thr, int eta, int lim);
        write_reg(CFG_OVERLAP, thr);
        write_reg(CFG_DECAY, eta);
        write_reg(CFG_MAX_KEPT, lim);
    endtask

    // Random frame: boxes clustered around one spot so that suppression bites,
    // few classes, some wild boxes, repeated scores and out-of-range classes.
    task automatic send_frame(int n);
        int bl, bt, bw, bh, l, t, r, b, s, c;
        bl = $urandom_range(0, 60000);
        bt = $urandom_range(0, 60000);
        bw = $urandom_range(0, 3000);
        bh = $urandom_range(0, 3000);
        s = $urandom_range(0, 65535);
        for (int i = 0; i < n; i++)
        begin
            l = bl + $urandom_range(0, 64);
            t = bt + $urandom_range(0, 64);
            r = l + bw + $urandom_range(0, 64);
            b = t + bh + $urandom_range(0, 64);
            if ($urandom_range(0, 9) == 0)
            begin
                l = $urandom_range(0, 65535);
                t = $urandom_range(0, 65535);
                r = $urandom_range(0, 65535);
                b = $urandom_range(0, 65535);
            end
            if ($urandom_range(0, 4) != 0)
                s = $urandom_range(0, 65535);
            case ($urandom_range(0, 9))
                0:       c = $urandom_range(0, 127);
                1:       c = $urandom_range(64, 79);
                default: c = $urandom_range(0, 2);
            endcase
            send_box(l, t, r, b, s, c, i == n - 1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frame at reset settings.
        send_box(0, 0, 65535, 65535, 65535, 79, 1'b0);   // widest box, top class
        send_box(0, 0, 65535, 65535, 65535, 0, 1'b0);    // same score, lower class
        send_box(100, 100, 400, 400, 50000, 5, 1'b0);
        send_box(100, 100, 400, 400, 49999, 5, 1'b0);    // duplicate, suppressed
        send_box(110, 110, 410, 410, 50000, 5, 1'b0);    // tie, later arrival
        send_box(100, 100, 400, 400, 40000, 6, 1'b0);    // same box, other class
        send_box(500, 500, 300, 300, 30000, 5, 1'b0);    // inverted box
        send_box(350, 350, 200, 900, 30001, 5, 1'b0);    // inverted width only
        send_box(0, 0, 0, 0, 0, 7, 1'b0);                 // zero score
        send_box(1, 2, 3, 4, 65535, 127, 1'b0);           // class out of range
        send_box(65535, 65535, 65535, 65535, 1, 64, 1'b0);
        send_box(200, 200, 600, 600, 20000, 5, 1'b1);
        // Empty frame: only an ignored box closes it.
        send_box(5, 5, 9, 9, 1000, 80, 1'b1);
        drain();

        // Extremes: zero threshold, full decay to zero, a single keep.
        set_regs(0, 0, 1);
        send_box(0, 0, 160, 160, 9000, 3, 1'b0);
        send_box(2000, 2000, 2160, 2160, 8000, 3, 1'b1);
        for (int f = 0; f < 6; f++)
            send_frame($urandom_range(1, 10));
        drain();

        // Most lenient threshold, decay off, full keep count.
        set_regs(65535, 65536, 64);
        for (int f = 0; f < 6; f++)
            send_frame($urandom_range(1, 12));
        drain();

        // Strong decay; hold the receiver so the block backs up on its input.
        set_regs(60000, 40000, 64);
        send_frame(12);
        hold_ticket++;
        for (int f = 0; f < 5; f++)
            send_frame($urandom_range(2, 10));
        drain();

        for (int p = 0; p < 4; p++)
        begin
            set_regs($urandom_range(0, 65535), $urandom_range(0, 65536), $urandom_range(1, 64));
            for (int f = 0; f < 6; f++)
                send_frame($urandom_range(1, 12));
            drain();
        end

        // Closing phase without idling.
        calm = 1'b1;
        set_regs($urandom_range(20000, 50000), $urandom_range(30000, 65535), 64);
        for (int f = 0; f < 5; f++)
            send_frame($urandom_range(1, 12));
        drain();

        $display("Sent %0d boxes in %0d frames (%0d overflowed), checked %0d result words",
                 boxes_sent, frames_closed, overflow_frames, words_checked);
        $display("Settings swept thresholds and decay from zero to full, keep counts 1 to 64");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
